// ----- design/ssatw_pkg.sv -----
// Shared types and codes for the setpoint settle and tolerance watch block.
package ssatw_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned TIMER_W    = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 8;

    // Stable count needed to declare settling, in seconds.
    localparam logic [7:0] SETTLE_STABLE = 8'd2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_ABORT = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_SETTLED = 3'd1,
        ST_SUCCESS = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_TOLERR  = 3'd4,
        ST_COMMERR = 3'd5,
        ST_ABORTED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        VALVE_NONE     = 2'd0,
        VALVE_PRESSURE = 2'd1,
        VALVE_CLOSE    = 2'd2
    } valve_t;

    typedef enum logic [1:0] {
        ALARM_NONE = 2'd0,
        ALARM_COMM = 2'd1,
        ALARM_TOL  = 2'd2
    } alarm_t;

    typedef enum logic [1:0] {
        AOPT_IGNORE = 2'd0,
        AOPT_WARN   = 2'd1,
        AOPT_FAIL   = 2'd2,
        AOPT_ABORT  = 2'd3
    } alarm_opt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_ALARM_OPT = 3'd3,
        REG_MON_EN    = 3'd4,
        REG_STABLE    = 3'd5,
        REG_DELAY     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] setpoint;
        logic [15:0] tolerance;
        logic [15:0] timeout_seconds;
        alarm_opt_t  alarm_option;
        logic        monitor_enable;
        logic [7:0]  stable_seconds;
        logic [7:0]  delay_seconds;
    } cfg_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [SAMPLE_W-1:0]   sample;
        logic                  comm_ok;
    } item_t;

    typedef struct packed {
        status_t status;
        valve_t  valve_action;
        alarm_t  alarm;
        logic    module_fail;
        logic    done_res;
    } result_t;

endpackage

// ----- design/ssatw_band.sv -----
// Tolerance band compare: setpoint - tolerance <= sample <= setpoint + tolerance.
module ssatw_band (
    input  logic [ssatw_pkg::SAMPLE_W-1:0] sample,
    input  logic [15:0]                    setpoint,
    input  logic [15:0]                    tolerance,
    output logic                           in_band
);
    import ssatw_pkg::*;

    logic [16:0] low_sum;
    logic [16:0] high_sum;

    assign low_sum  = {1'b0, sample} + {1'b0, tolerance};
    assign high_sum = {1'b0, setpoint} + {1'b0, tolerance};
    assign in_band  = (low_sum >= {1'b0, setpoint}) && ({1'b0, sample} <= high_sum);

endmodule

// ----- design/ssatw_ctrl.sv -----
// Run sequencer: phase, counters and per-item result decision.
module ssatw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  ssatw_pkg::item_t   item,
    input  logic               in_band,
    input  ssatw_pkg::cfg_t    cfg,
    output ssatw_pkg::result_t result
);
    import ssatw_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DELAY  = 2'd1,
        PH_SETTLE = 2'd2,
        PH_WATCH  = 2'd3
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               first_reg, first_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;

    logic [COUNT_W-1:0] count_up;
    logic [COUNT_W-1:0] count_dn;
    logic [COUNT_W-1:0] count_new;
    logic [TIMER_W-1:0] timer_inc;
    logic               outside;

    assign count_up  = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign count_dn  = (count_reg == '0) ? count_reg : count_reg - 1'b1;
    assign timer_inc = timer_reg + 1'b1;
    assign outside   = !in_band;

    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        count_new  = count_reg;
        result     = '{status: ST_RUN, valve_action: VALVE_NONE, alarm: ALARM_NONE,
                       module_fail: 1'b0, done_res: 1'b0};
        unique case (item.opcode)
            OP_START: begin
                count_next = '0;
                timer_next = '0;
                first_next = 1'b0;
                if (cfg.setpoint == '0) begin
                    result.valve_action = VALVE_CLOSE;
                    result.status       = ST_SUCCESS;
                    result.done_res     = 1'b1;
                    phase_next          = PH_IDLE;
                end else begin
                    result.valve_action = VALVE_PRESSURE;
                    if (!cfg.monitor_enable) begin
                        if (cfg.delay_seconds == '0) begin
                            result.status   = ST_SUCCESS;
                            result.done_res = 1'b1;
                            phase_next      = PH_IDLE;
                        end else begin
                            phase_next = PH_DELAY;
                        end
                    end else begin
                        phase_next = PH_SETTLE;
                        first_next = 1'b1;
                    end
                end
            end
            OP_ABORT: begin
                if (phase_reg != PH_IDLE) begin
                    result.status   = ST_ABORTED;
                    result.done_res = 1'b1;
                    phase_next      = PH_IDLE;
                end
            end
            OP_TICK: begin
                case (phase_reg)
                    PH_DELAY: begin
                        timer_next = timer_inc;
                        if (timer_inc >= {9'd0, cfg.delay_seconds, 1'b0}) begin
                            result.status   = ST_SUCCESS;
                            result.done_res = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                    end
                    PH_SETTLE: begin
                        first_next = 1'b0;
                        if (first_reg && !item.comm_ok) begin
                            result.alarm    = ALARM_COMM;
                            result.status   = ST_COMMERR;
                            result.done_res = 1'b1;
                            phase_next      = PH_IDLE;
                        end else begin
                            count_new  = in_band ? count_up : count_dn;
                            count_next = count_new;
                            if (count_new[COUNT_W-1:1] >= SETTLE_STABLE) begin
                                result.status = ST_SETTLED;
                                phase_next    = PH_WATCH;
                                count_next    = '0;
                                timer_next    = '0;
                            end else if (timer_reg[TIMER_W-1:1] >
                                         {1'b0, cfg.timeout_seconds}) begin
                                result.status   = ST_TIMEOUT;
                                result.done_res = 1'b1;
                                phase_next      = PH_IDLE;
                            end else begin
                                timer_next = timer_inc;
                            end
                        end
                    end
                    PH_WATCH: begin
                        count_new  = outside ? count_up : count_dn;
                        count_next = count_new;
                        if (outside && cfg.alarm_option != AOPT_IGNORE) begin
                            result.alarm = ALARM_TOL;
                            if (cfg.alarm_option == AOPT_FAIL) begin
                                result.module_fail = 1'b1;
                            end
                            if (cfg.alarm_option == AOPT_ABORT) begin
                                result.status   = ST_ABORTED;
                                result.done_res = 1'b1;
                                phase_next      = PH_IDLE;
                            end
                        end
                        if (!result.done_res) begin
                            if (count_new[COUNT_W-1:1] >= cfg.stable_seconds) begin
                                result.status   = ST_TOLERR;
                                result.done_res = 1'b1;
                                phase_next      = PH_IDLE;
                            end else begin
                                timer_next = timer_inc;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            first_reg <= 1'b0;
            count_reg <= '0;
            timer_reg <= '0;
        end else if (adv) begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ----- design/setpoint_settle_and_tolerance_watch.sv -----
// Top level: config registers, input register, sequencer and result register.
//
//  channel  | ports                             | payload (low bit up)
//  ---------+-----------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | tuser: opcode; tdata: sample, comm_ok
//  result   | m_tvalid m_tready m_tdata m_tlast | tdata: status, valve_action, alarm,
//           |                                   |        module_fail; tlast: done_res
//  config   | cfg_wr_en cfg_index cfg_wdata     | register index 0..6, data in low bits
//
// One transfer per cycle is sustained while the sink does not stall; an item is held in
// the input register until it advances into the result register, from which its result
// is offered.
// The only loop is the sequencer state update, done in the advancing cycle.
// Reset is synchronous active low and clears both stage valids, the sequencer state and
// the config registers to their defaults. A stalled result holds its register; the input
// register still takes a new item when the result register frees in the same cycle.
module setpoint_settle_and_tolerance_watch (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [ssatw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssatw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssatw_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample, [16] comm_ok
    input  logic [1:0]                          s_tuser,   // [1:0] opcode
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ssatw_pkg::M_TDATA_W-1:0]     m_tdata,   // [2:0] status, [4:3] valve_action,
                                                           // [6:5] alarm, [7] module_fail
    output logic                                m_tlast    // done_res
);
    import ssatw_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    in_band;
    logic    adv;

    // Move the held item into the result stage when that stage is empty or draining.
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Config registers; a write lands at its edge, so write only while nothing is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint        <= '0;
            cfg_reg.tolerance       <= '0;
            cfg_reg.timeout_seconds <= '0;
            cfg_reg.alarm_option    <= AOPT_WARN;
            cfg_reg.monitor_enable  <= 1'b1;
            cfg_reg.stable_seconds  <= 8'd2;
            cfg_reg.delay_seconds   <= 8'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETPOINT:  cfg_reg.setpoint        <= cfg_wdata;
                REG_TOLERANCE: cfg_reg.tolerance       <= cfg_wdata;
                REG_TIMEOUT:   cfg_reg.timeout_seconds <= cfg_wdata;
                REG_ALARM_OPT: cfg_reg.alarm_option    <= alarm_opt_t'(cfg_wdata[1:0]);
                REG_MON_EN:    cfg_reg.monitor_enable  <= cfg_wdata[0];
                REG_STABLE:    cfg_reg.stable_seconds  <= cfg_wdata[7:0];
                REG_DELAY:     cfg_reg.delay_seconds   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input register: capture on each input transfer, drop valid when advanced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode  <= opcode_t'(s_tuser);
            in_item_reg.sample  <= s_tdata[SAMPLE_W-1:0];
            in_item_reg.comm_ok <= s_tdata[SAMPLE_W];
        end
    end

    ssatw_band u_band (
        .sample    (in_item_reg.sample),
        .setpoint  (cfg_reg.setpoint),
        .tolerance (cfg_reg.tolerance),
        .in_band   (in_band)
    );

    ssatw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (in_item_reg),
        .in_band (in_band),
        .cfg     (cfg_reg),
        .result  (res)
    );

    // Result register: load on advance, hold while the sink stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.module_fail, out_res_reg.alarm,
                       out_res_reg.valve_action, out_res_reg.status};
    assign m_tlast  = out_res_reg.done_res;

endmodule
